// ----- rtl/core/html_entity_unescape_unit_defines.svh -----
// assertion helpers used by html_entity_unescape_unit
`ifndef HTML_ENTITY_UNESCAPE_UNIT_DEFINES_SVH
`define HTML_ENTITY_UNESCAPE_UNIT_DEFINES_SVH

// property that holds at every clock edge out of reset
`define HEU_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define HEU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/heu_pkg.sv -----
package heu_pkg;

  localparam int unsigned NumEnt     = 6;
  localparam int unsigned TailLen    = 5;
  localparam int unsigned MaxHeld    = 4;
  localparam int unsigned MaxResults = 6;

  typedef logic [7:0] byte_t;

  localparam byte_t Amp = 8'h26;  // '&'

  // entity tails after the ampersand, zero padded
  localparam byte_t EntTail [NumEnt][TailLen] = '{
    '{8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},  // lt;
    '{8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},  // gt;
    '{8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},  // amp;
    '{8'h23, 8'h33, 8'h39, 8'h3b, 8'h00},  // #39;
    '{8'h23, 8'h34, 8'h37, 8'h3b, 8'h00},  // #47;
    '{8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b}   // quot;
  };

  localparam logic [2:0] EntLen [NumEnt] = '{3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd5};

  localparam byte_t EntVal [NumEnt] = '{8'h3c, 8'h3e, 8'h26, 8'h27, 8'h2f, 8'h22};

endpackage

// ----- rtl/core/html_entity_unescape_unit.sv -----
// HTML entity decoder for a byte stream. Decodes &lt; &gt; &amp; &#39; &#47; and
// &quot; (case sensitive); every other byte passes through. Bytes after an
// ampersand are held while they still match an entity prefix and are flushed
// literally on a mismatch or at end of string, so one input transaction gives zero
// to six output transactions. The input byte is decoded combinationally into a
// six-entry result buffer; a new byte is accepted every cycle while each byte yields
// at most one result and out_ready_i is high; a flush of n results holds the input while
// the buffer drains one byte per ready cycle. Results appear the cycle after acceptance.
module html_entity_unescape_unit
  import heu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_string_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  logic [2:0] hc_q, hc_d;
  byte_t      held_q [MaxHeld];
  byte_t      buf_q  [MaxResults];
  byte_t      seq    [MaxResults];
  logic [2:0] cnt_q, cnt_d;
  logic [2:0] idx_q;
  logic       eos_q;
  logic [2:0] k;
  logic       full, pre, hold_wr;
  byte_t      full_val;
  logic       in_fire, out_fire;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  assign out_valid_o = (idx_q != cnt_q);
  assign in_ready_o  = !out_valid_o || (((idx_q + 3'd1) == cnt_q) && out_ready_i);
  assign out_byte_o  = buf_q[idx_q];
  assign last_o      = eos_q && ((idx_q + 3'd1) == cnt_q);

  assign k = hc_q - 3'd1;

  // match the held bytes plus the current byte against each entity tail
  always_comb begin
    logic  ok;
    byte_t tk;
    full     = 1'b0;
    pre      = 1'b0;
    full_val = Amp;
    for (int e = 0; e < NumEnt; e++) begin
      ok = (EntLen[e] >= (k + 3'd1));
      for (int i = 0; i < MaxHeld; i++) begin
        if ((3'(i) < k) && (EntTail[e][i] != held_q[i])) ok = 1'b0;
      end
      tk = 8'h00;
      for (int i = 0; i < TailLen; i++) begin
        if (k == 3'(i)) tk = EntTail[e][i];
      end
      if (ok && (tk == data_byte_i)) begin
        if (EntLen[e] == (k + 3'd1)) begin
          full     = 1'b1;
          full_val = EntVal[e];
        end else begin
          pre = 1'b1;
        end
      end
    end
  end

  // result sequence: ampersand, held bytes, current byte at position hc_q
  always_comb begin
    seq[0] = Amp;
    for (int i = 1; i <= MaxHeld; i++) seq[i] = held_q[i-1];
    seq[MaxResults-1] = data_byte_i;
    for (int i = 0; i < MaxResults; i++) begin
      if (hc_q == 3'(i)) seq[i] = data_byte_i;
    end
    hold_wr = 1'b0;
    hc_d    = 3'd0;
    cnt_d   = hc_q + 3'd1;
    priority if (hc_q == 3'd0) begin
      if ((data_byte_i == Amp) && !end_of_string_i) begin
        hc_d  = 3'd1;
        cnt_d = 3'd0;
      end
    end else if (full) begin
      seq[0] = full_val;
      cnt_d  = 3'd1;
    end else if (pre && !k[2]) begin
      if (!end_of_string_i) begin
        hold_wr = 1'b1;
        hc_d    = hc_q + 3'd1;
        cnt_d   = 3'd0;
      end
    end else begin
      // mismatch: flush, then a fresh ampersand starts a new hold
      if ((data_byte_i == Amp) && !end_of_string_i) begin
        hc_d  = 3'd1;
        cnt_d = hc_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q  <= 3'd0;
      cnt_q <= 3'd0;
      idx_q <= 3'd0;
    end else if (in_fire) begin
      hc_q  <= hc_d;
      cnt_q <= cnt_d;
      idx_q <= 3'd0;
    end else if (out_fire) begin
      idx_q <= idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      eos_q <= end_of_string_i;
      for (int i = 0; i < MaxResults; i++) buf_q[i] <= seq[i];
      if (hold_wr) held_q[k[1:0]] <= data_byte_i;
    end
  end

`include "html_entity_unescape_unit_defines.svh"

  `HEU_ASSERT(a_idx_bound, idx_q <= cnt_q, "read pointer past result count")
  `HEU_ASSERT(a_hold_bound, hc_q <= 3'(MaxHeld + 1), "hold count out of range")
  `HEU_ASSERT(a_cnt_bound, cnt_q <= 3'(MaxResults), "result count out of range")
  `HEU_ASSERT_NEXT(a_plain_out, in_fire && (hc_q == 3'd0) && (data_byte_i != Amp), out_valid_o && (cnt_q == 3'd1), "plain byte gave no single result")
  `HEU_ASSERT_NEXT(a_eos_flush, in_fire && end_of_string_i, hc_q == 3'd0, "bytes still held after end of string")

endmodule

// ----- dv/heu_tb_pkg.sv -----
package heu_tb_pkg;
  import heu_pkg::*;

  typedef struct packed {
    byte_t ch;
    logic  last;
  } out_char_t;

  class unescape_scoreboard;
    // tails that follow the ampersand, and the byte each one decodes to
    string ent_tail [6] = '{"lt;", "gt;", "amp;", "#39;", "#47;", "quot;"};
    byte_t ent_char [6] = '{8'h3c, 8'h3e, 8'h26, 8'h27, 8'h2f, 8'h22};

    byte_t       held [4];
    int unsigned held_len;  // 0 when idle, else 1 + bytes held after the ampersand
    out_char_t   expected_text [$];
    int unsigned n_inputs, n_outputs, n_decoded, n_flushes, errors;

    function void emit(byte_t ch, logic last);
      expected_text.push_back(out_char_t'{ch, last});
    endfunction

    function void flush_held();
      emit(Amp, 1'b0);
      for (int i = 0; i < int'(held_len) - 1; i++) emit(held[i], 1'b0);
      n_flushes++;
    endfunction

    function int pending();
      return expected_text.size();
    endfunction

    function void decode_input(byte_t b, logic eos);
      int k;
      int full;
      bit partial;
      bit ok;
      n_inputs++;
      if (held_len != 0) begin
        k       = int'(held_len) - 1;
        full    = -1;
        partial = 1'b0;
        for (int e = 0; e < 6; e++) begin
          ok = ent_tail[e].len() > k;
          for (int i = 0; ok && i < k; i++) begin
            if (ent_tail[e][i] != held[i]) ok = 1'b0;
          end
          if (ok && ent_tail[e][k] == b) begin
            if (ent_tail[e].len() == k + 1) full = e;
            else partial = 1'b1;
          end
        end
        if (full >= 0) begin
          emit(ent_char[full], eos);
          held_len = 0;
          n_decoded++;
          return;
        end
        if (partial && !eos) begin
          held[k]  = b;
          held_len = k + 2;
          return;
        end
        flush_held();
        held_len = 0;
        // string ended on a still-matching prefix: current byte closes it
        if (partial) begin
          emit(b, 1'b1);
          return;
        end
      end
      if (b == Amp && !eos) held_len = 1;
      else emit(b, eos);
    endfunction

    function void check_output(byte_t ch, logic last);
      out_char_t exp_c;
      n_outputs++;
      if (expected_text.size() == 0) begin
        $error("unexpected output transaction: out_byte %h last %b", ch, last);
        errors++;
        return;
      end
      exp_c = expected_text.pop_front();
      if (ch !== exp_c.ch) begin
        $error("out_byte: expected %h, actual %h", exp_c.ch, ch);
        errors++;
      end
      if (last !== exp_c.last) begin
        $error("last: expected %b, actual %b", exp_c.last, last);
        errors++;
      end
    endfunction
  endclass

endpackage

// ----- dv/tb_html_entity_unescape_unit.sv -----
module tb_html_entity_unescape_unit
  import heu_pkg::*;
  import heu_tb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        end_of_string_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_byte_o;
  logic        last_o;

  int unsigned        cycles = 0;
  int unsigned        n_strings = 0;
  bit                 idle_en = 1'b1;
  unescape_scoreboard board;

  html_entity_unescape_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_string_i(end_of_string_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always_ff @(posedge clk_i) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CycleLimit);
    $display("html_entity_unescape_unit test failed");
    $finish;
  end

  // called just after a falling edge; returns just after a falling edge, once the byte is accepted
  task automatic send_byte(input byte_t b, input logic eos);
    int gap;
    gap = idle_en ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    end_of_string_i <= eos;
    do @(posedge clk_i); while (!in_ready_o);
    board.decode_input(b, eos);
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    n_strings++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // mostly entity-shaped text: full entities, cut-off prefixes, corrupted tails
  task automatic send_random_string();
    byte_t txt [$];
    string alpha = "&ltgampq#3947;uo";
    int    pieces;
    int    kind;
    int    e;
    int    j;
    int    len;
    pieces = $urandom_range(1, 4);
    repeat (pieces) begin
      kind = $urandom_range(0, 9);
      e    = $urandom_range(0, 5);
      len  = board.ent_tail[e].len();
      case (kind)
        0, 1: txt.push_back(byte_t'($urandom_range(0, 255)));
        2, 3, 4: begin
          txt.push_back(Amp);
          for (int i = 0; i < len; i++) txt.push_back(board.ent_tail[e][i]);
        end
        5, 6: begin
          j = $urandom_range(0, len - 1);
          txt.push_back(Amp);
          for (int i = 0; i < j; i++) txt.push_back(board.ent_tail[e][i]);
        end
        7: begin
          j = $urandom_range(0, len - 1);
          txt.push_back(Amp);
          for (int i = 0; i < len; i++) begin
            txt.push_back(i == j ? byte_t'($urandom_range(0, 255)) : board.ent_tail[e][i]);
          end
        end
        default: begin
          repeat ($urandom_range(1, 3)) txt.push_back(alpha[$urandom_range(0, alpha.len() - 1)]);
        end
      endcase
    end
    foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
    n_strings++;
  endtask

  // result side: random stall before each output transaction
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = idle_en ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      board.check_output(out_byte_o, last_o);
      @(negedge clk_i);
    end
  end

  initial begin
    bit paused;
    board           = new();
    paused          = 1'b0;
    in_valid_i      = 1'b0;
    data_byte_i     = 8'h00;
    end_of_string_i = 1'b0;
    rst_ni          = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // entity closing the string, lone ampersand at the end, mismatch at the end,
    // longest hold then mismatch (six results), end inside a prefix, re-armed hold
    send_text("&lt;");
    send_text("&");
    send_text("&amZ");
    send_text("&quotx");
    send_text("&#4");
    send_text("&&gt;");
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    n_strings++;
    wait_drained();

    while (board.n_inputs < 275) begin
      if ($urandom_range(0, 9) == 0) idle_en = ~idle_en;
      if (!paused && board.n_inputs >= 170) begin
        wait_drained();
        paused = 1'b1;
      end
      send_random_string();
    end
    in_valid_i <= 1'b0;

    while (board.pending() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    $display("%0d strings, %0d input bytes, %0d output bytes checked",
             n_strings, board.n_inputs, board.n_outputs);
    $display("%0d entities decoded, %0d held sequences flushed literally",
             board.n_decoded, board.n_flushes);
    if (board.errors == 0) begin
      $display("html_entity_unescape_unit test passed");
    end else begin
      $display("html_entity_unescape_unit test failed");
    end
    $finish;
  end

endmodule
